// ===== rtl/lp_pkg.sv =====
package lp_pkg;

	localparam int ORDER_W = 6;
	localparam int ARG_W = 18;
	localparam int VALUE_W = 18;
	localparam int SLOPE_W = 27;

	localparam int MAX_ORDER_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;

	// quotient bits resolved per divider cycle
	localparam int DIV_DIGIT = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_COMB,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ===== rtl/lp_if.sv =====
interface lp_req_if import lp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [ORDER_W-1:0]      order;
	logic signed [ARG_W-1:0] arg;

	modport source (output valid, output order, output arg, input ready);
	modport sink (input valid, input order, input arg, output ready);
endinterface

interface lp_rsp_if import lp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] poly_value;
	logic signed [SLOPE_W-1:0] poly_slope;

	modport source (output valid, output poly_value, output poly_slope, input ready);
	modport sink (input valid, input poly_value, input poly_slope, output ready);
endinterface

// ===== rtl/lp_div.sv =====
module lp_div import lp_pkg::*; #(
	parameter int NW = 37,
	parameter int KW = 6,
	parameter int DIGIT = DIV_DIGIT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic [KW-1:0]        divisor,
	output div_sts_t             sts,
	output logic signed [NW-1:0] quot
);

	localparam int DCNT = (NW + DIGIT - 1) / DIGIT;
	localparam int DPW = DCNT * DIGIT;
	localparam int CW = $clog2(DCNT + 1);

	logic            busy_q;
	logic [CW-1:0]   cnt_q;
	logic            neg_q;
	logic [KW-1:0]   rem_q;
	logic [KW-1:0]   dvs_q;
	logic [DPW-1:0]  dq_q;
	logic [KW-1:0]   rem_d;
	logic [DPW-1:0]  dq_d;
	logic [NW-1:0]   mag;
	logic [NW-1:0]   qmag;

	assign mag = num[NW-1] ? NW'(-num) : NW'(num);

	// one digit of restoring division, one bit per inner step
	always_comb begin
		logic [KW:0]    t;
		logic [KW-1:0]  r;
		logic [DPW-1:0] d;
		r = rem_q;
		d = dq_q;
		for (int i = 0; i < DIGIT; i++) begin
			t = {r, d[DPW-1]};
			d = {d[DPW-2:0], 1'b0};
			if (t >= {1'b0, dvs_q}) begin
				t = t - {1'b0, dvs_q};
				d[0] = 1'b1;
			end
			r = t[KW-1:0];
		end
		rem_d = r;
		dq_d = d;
	end

	assign qmag = dq_d[NW-1:0];
	assign quot = neg_q ? -$signed(qmag) : $signed(qmag);
	assign sts.busy = busy_q;
	assign sts.done = busy_q && (cnt_q == CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(DCNT);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q <= DPW'(mag);
			rem_q <= '0;
			neg_q <= num[NW-1];
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q <= dq_d;
			rem_q <= rem_d;
		end
	end

endmodule

// ===== rtl/legendre_value_and_slope.sv =====
// the value and slope lanes share one fixed point multiplier and one divider resolving
// 8 quotient bits a cycle; one request in flight at a time
// throughput: a new request is taken the cycle after its result is registered
// reset: arst_n asynchronous active low, returns the sequencer to idle with no result pending
module legendre_value_and_slope import lp_pkg::*; #(
	parameter int MAX_ORDER = MAX_ORDER_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	lp_req_if.sink   req,
	lp_rsp_if.source rsp
);

	localparam int MAXS = MAX_ORDER * (MAX_ORDER + 1) / 2;
	localparam int VW = FRAC_BITS + $clog2(MAXS + 1) + 2;
	localparam int XW = FRAC_BITS + 2;
	localparam int MW = VW + 1;
	localparam int KW = $clog2(MAX_ORDER + 1);
	localparam int NW = MW + KW + 2;
	localparam int CMPW = ((VW > SLOPE_W) ? VW : SLOPE_W) + 1;

	localparam logic signed [VW-1:0] ONE_V = VW'(longint'(1) << FRAC_BITS);
	localparam logic signed [31:0] ONE_A = 32'(longint'(1) << FRAC_BITS);
	localparam logic signed [CMPW-1:0] ONE_C = CMPW'(longint'(1) << FRAC_BITS);
	localparam logic signed [CMPW-1:0] SLOPE_LIM = CMPW'((longint'(1) << (SLOPE_W - 1)) - 1);

	state_t                    state_q, state_d;
	logic                      lane_q;
	logic [KW-1:0]             k_q;
	logic [KW-1:0]             n_q;
	logic                      ovalid_q;
	logic signed [XW-1:0]      x_q;
	logic signed [VW-1:0]      pp_q, pc_q, dp_q, dc_q, pn_q;
	logic signed [MW-1:0]      m_q;
	logic signed [VALUE_W-1:0] val_q;
	logic signed [SLOPE_W-1:0] slp_q;

	logic                      accept;
	logic                      out_load;
	logic                      last_step;
	logic [KW-1:0]             n_in;
	logic signed [31:0]        a_ext;
	logic signed [31:0]        x_clamp;

	logic signed [VW-1:0]      v_sel;
	logic [XW-2:0]             ax;
	logic [VW-1:0]             av;
	logic [VW+XW-2:0]          prod;
	logic [MW-1:0]             fx_mag;
	logic signed [MW-1:0]      fx;
	logic signed [MW-1:0]      m_d;

	logic [KW:0]               c1;
	logic [KW-1:0]             c2;
	logic signed [VW-1:0]      prev_sel;
	logic signed [NW-2:0]      t1, t2;
	logic signed [NW-1:0]      num;

	div_sts_t                  div_sts;
	logic signed [NW-1:0]      quot;
	logic signed [VW-1:0]      q;

	logic signed [CMPW-1:0]    pe, de, pv, dv;

	// request staging
	assign a_ext = 32'(req.arg);
	assign x_clamp = (a_ext > ONE_A) ? ONE_A : ((a_ext < -ONE_A) ? -ONE_A : a_ext);
	assign n_in = ({26'd0, req.order} > 32'(MAX_ORDER)) ? KW'(MAX_ORDER) : KW'(req.order);

	// shared fixed point multiply, truncated toward zero
	assign v_sel = lane_q ? dc_q : pc_q;
	assign ax = x_q[XW-1] ? (XW-1)'(-x_q) : x_q[XW-2:0];
	assign av = v_sel[VW-1] ? VW'(-v_sel) : VW'(v_sel);
	assign prod = {{(XW-1){1'b0}}, av} * {{VW{1'b0}}, ax};
	assign fx_mag = prod[FRAC_BITS +: MW];
	assign fx = (x_q[XW-1] != v_sel[VW-1]) ? -$signed(fx_mag) : $signed(fx_mag);
	assign m_d = lane_q ? (fx + MW'(pc_q)) : fx;

	// recurrence numerator
	assign c1 = {k_q, 1'b0} - (KW+1)'(1);
	assign c2 = k_q - KW'(1);
	assign prev_sel = lane_q ? dp_q : pp_q;
	assign t1 = $signed({1'b0, c1}) * m_q;
	assign t2 = $signed({1'b0, c2}) * prev_sel;
	assign num = NW'(t1) - NW'(t2);

	lp_div #(
		.NW(NW),
		.KW(KW),
		.DIGIT(DIV_DIGIT)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(state_q == ST_COMB),
		.num(num),
		.divisor(k_q),
		.sts(div_sts),
		.quot(quot)
	);

	assign q = quot[VW-1:0];
	assign last_step = lane_q && (k_q == n_q);

	always_comb begin
		state_d = state_q;
		req.ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = (n_in < KW'(2)) ? ST_FIN : ST_MUL;
				end
			end
			ST_MUL: state_d = ST_COMB;
			ST_COMB: state_d = ST_DIV;
			ST_DIV: begin
				if (div_sts.done) begin
					state_d = last_step ? ST_FIN : ST_MUL;
				end
			end
			ST_FIN: begin
				if (!ovalid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lane_q <= 1'b0;
			k_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				lane_q <= 1'b0;
				k_q <= KW'(2);
			end else if (state_q == ST_DIV && div_sts.done) begin
				lane_q <= !lane_q;
				if (lane_q && !last_step) begin
					k_q <= k_q + KW'(1);
				end
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= x_clamp[XW-1:0];
			n_q <= n_in;
			pp_q <= ONE_V;
			dp_q <= '0;
			if (n_in == '0) begin
				pc_q <= ONE_V;
				dc_q <= '0;
			end else begin
				pc_q <= VW'(x_clamp);
				dc_q <= ONE_V;
			end
		end else if (state_q == ST_DIV && div_sts.done) begin
			if (!lane_q) begin
				pn_q <= q;
			end else begin
				pp_q <= pc_q;
				pc_q <= pn_q;
				dp_q <= dc_q;
				dc_q <= q;
			end
		end
		if (state_q == ST_MUL) begin
			m_q <= m_d;
		end
		if (out_load) begin
			val_q <= pv[VALUE_W-1:0];
			slp_q <= dv[SLOPE_W-1:0];
		end
	end

	// output saturation
	assign pe = CMPW'(pc_q);
	assign de = CMPW'(dc_q);
	assign pv = (pe > ONE_C) ? ONE_C : ((pe < -ONE_C) ? -ONE_C : pe);
	assign dv = (de > SLOPE_LIM) ? SLOPE_LIM : ((de < -SLOPE_LIM) ? -SLOPE_LIM : de);

	assign rsp.valid = ovalid_q;
	assign rsp.poly_value = val_q;
	assign rsp.poly_slope = slp_q;

	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !div_sts.busy)
		else $error("request taken while divider busy");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second request taken during work");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_COMB || state_q == ST_DIV)
		|-> (k_q >= KW'(2) && k_q <= n_q))
		else $error("recurrence index out of range");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> state_q == ST_DIV)
		else $error("divider finished outside divide state");

endmodule

// ===== test/tb_top.sv =====
module tb_top import lp_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ONE_FX = longint'(1) << FRAC_BITS_DEF;
	localparam longint FRAC_MASK = ONE_FX - 1;
	localparam longint SLOPE_LIM = (longint'(1) << (SLOPE_W - 1)) - 1;
	localparam int N_RANDOM = 1500;
	localparam int LONG_HOLD = 700;

	typedef struct {
		logic [ORDER_W-1:0]      order;
		logic signed [ARG_W-1:0] arg;
		bit                      drain;
	} request_t;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic signed [SLOPE_W-1:0] slope;
	} value_slope_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                    drv_valid = 1'b0;
	logic [ORDER_W-1:0]      drv_order = '0;
	logic signed [ARG_W-1:0] drv_arg = '0;
	logic                    rdy = 1'b0;

	request_t     pending[$];
	value_slope_t expected_pairs[$];
	request_t     next_req;
	value_slope_t got_pair;
	value_slope_t want_pair;

	int mismatches = 0;
	int results_seen = 0;
	int send_idle = 0;
	int send_burst = 0;
	int recv_hold = 0;
	int recv_burst = 0;
	bit long_hold_done = 1'b0;
	int roll;

	lp_req_if req_if ();
	lp_rsp_if rsp_if ();

	assign req_if.valid = drv_valid;
	assign req_if.order = drv_order;
	assign req_if.arg = drv_arg;
	assign rsp_if.ready = rdy;

	legendre_value_and_slope dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// (x * v) >> frac, truncated toward zero
	function automatic longint scaled_product(longint x, longint v);
		longint unsigned ax, av, hi, lo;
		longint r;
		ax = (x < 0) ? -x : x;
		av = (v < 0) ? -v : v;
		hi = (av >> FRAC_BITS_DEF) * ax;
		lo = ((av & FRAC_MASK) * ax) >> FRAC_BITS_DEF;
		r = hi + lo;
		return ((x < 0) != (v < 0)) ? -r : r;
	endfunction

	function automatic value_slope_t legendre_pair(logic [ORDER_W-1:0] order,
			logic signed [ARG_W-1:0] arg);
		longint n, x, p_prev, p_cur, d_prev, d_cur, p_next, d_next;
		value_slope_t res;
		n = order;
		if (n > MAX_ORDER_DEF)
			n = MAX_ORDER_DEF;
		x = arg;
		if (x > ONE_FX)
			x = ONE_FX;
		if (x < -ONE_FX)
			x = -ONE_FX;
		p_prev = ONE_FX;
		d_prev = 0;
		p_cur = x;
		d_cur = ONE_FX;
		if (n == 0) begin
			p_cur = ONE_FX;
			d_cur = 0;
		end
		for (longint k = 2; k <= n; k++) begin
			p_next = ((2 * k - 1) * scaled_product(x, p_cur) - (k - 1) * p_prev) / k;
			d_next = ((2 * k - 1) * (scaled_product(x, d_cur) + p_cur)
				- (k - 1) * d_prev) / k;
			p_prev = p_cur;
			p_cur = p_next;
			d_prev = d_cur;
			d_cur = d_next;
		end
		if (p_cur > ONE_FX)
			p_cur = ONE_FX;
		if (p_cur < -ONE_FX)
			p_cur = -ONE_FX;
		if (d_cur > SLOPE_LIM)
			d_cur = SLOPE_LIM;
		if (d_cur < -SLOPE_LIM)
			d_cur = -SLOPE_LIM;
		res.value = p_cur[VALUE_W-1:0];
		res.slope = d_cur[SLOPE_W-1:0];
		return res;
	endfunction

	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic queue_request(int o, int a);
		request_t r;
		r.order = ORDER_W'(o);
		r.arg = ARG_W'(a);
		r.drain = 1'b0;
		pending.insert(pending.size(), r);
	endtask

	task automatic note_error(string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic int random_order();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return $urandom_range(0, 6);
		if (r < 85)
			return $urandom_range(7, 20);
		if (r < 95)
			return $urandom_range(21, 32);
		return $urandom_range(33, 63);
	endfunction

	function automatic int random_arg();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return $urandom_range(0, (1 << ARG_W) - 1);
		if (r < 25) begin
			case ($urandom_range(0, 5))
				0: return 0;
				1: return 65536;
				2: return -65536;
				3: return 65535;
				4: return -65535;
				default: return 65537;
			endcase
		end
		return int'($urandom_range(0, 131072)) - 65536;
	endfunction

	// request side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			send_idle <= 0;
		end else begin
			if (drv_valid && req_if.ready)
				expected_pairs.insert(expected_pairs.size(),
					legendre_pair(drv_order, drv_arg));
			if (!drv_valid || req_if.ready) begin
				if (send_idle > 0) begin
					send_idle <= send_idle - 1;
					drv_valid <= 1'b0;
				end else if (pending.size() != 0
						&& (!pending[0].drain || expected_pairs.size() == 0)) begin
					next_req = pending.pop_front();
					drv_valid <= 1'b1;
					drv_order <= next_req.order;
					drv_arg <= next_req.arg;
					if (send_burst > 0) begin
						send_burst <= send_burst - 1;
						send_idle <= 0;
					end else if ($urandom_range(0, 99) < 3) begin
						send_burst <= $urandom_range(20, 60);
						send_idle <= 0;
					end else begin
						send_idle <= idle_length();
					end
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// result side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy <= 1'b0;
			recv_hold <= 0;
		end else begin
			if (rsp_if.valid && rdy) begin
				results_seen++;
				got_pair.value = rsp_if.poly_value;
				got_pair.slope = rsp_if.poly_slope;
				if (expected_pairs.size() == 0) begin
					note_error($sformatf("unexpected result value %0d slope %0d",
						got_pair.value, got_pair.slope));
				end else begin
					want_pair = expected_pairs.pop_front();
					if (got_pair.value !== want_pair.value)
						note_error($sformatf("poly_value got %0d want %0d",
							got_pair.value, want_pair.value));
					if (got_pair.slope !== want_pair.slope)
						note_error($sformatf("poly_slope got %0d want %0d",
							got_pair.slope, want_pair.slope));
				end
			end
			if (recv_hold > 0) begin
				recv_hold <= recv_hold - 1;
				rdy <= 1'b0;
			end else if (!long_hold_done && results_seen >= 150) begin
				long_hold_done <= 1'b1;
				recv_hold <= LONG_HOLD;
				rdy <= 1'b0;
			end else if (recv_burst > 0) begin
				recv_burst <= recv_burst - 1;
				rdy <= 1'b1;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 3) begin
					recv_burst <= $urandom_range(50, 300);
					rdy <= 1'b1;
				end else if (roll < 8) begin
					recv_hold <= idle_length();
					rdy <= 1'b0;
				end else begin
					rdy <= (roll >= 30);
				end
			end
		end
	end

	initial begin
		queue_request(0, 0);
		queue_request(0, 65536);
		queue_request(1, -65536);
		queue_request(1, 131071);
		queue_request(1, -131072);
		queue_request(2, 65536);
		queue_request(2, -65536);
		queue_request(2, 0);
		queue_request(3, 32768);
		queue_request(32, 65536);
		queue_request(32, -65536);
		queue_request(32, 0);
		queue_request(32, 12345);
		queue_request(33, -40000);
		queue_request(63, 65537);
		queue_request(63, -65537);
		queue_request(5, -1);
		queue_request(7, 1);
		queue_request(10, 131071);
		queue_request(4, -131072);
		queue_request(32, -65535);
		for (int i = 0; i < N_RANDOM; i++)
			queue_request(random_order(), random_arg());
		// wait for the block to empty before these requests
		pending[400].drain = 1'b1;
		pending[1000].drain = 1'b1;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || drv_valid)
			@(posedge clk);
		while (expected_pairs.size() != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);

		if (mismatches == 0)
			$display("PASS legendre_value_and_slope");
		else
			$display("FAIL legendre_value_and_slope");
		$finish;
	end

	initial begin
		#60ms;
		$display("FAIL legendre_value_and_slope");
		$finish;
	end

endmodule
